/* hdl/assert_macros.svh */
// Assertion macros shared by the blob field renderer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("abfr check failed");

// Next-cycle implication, checked outside reset.
`define ABFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("abfr check failed");

`endif

/* hdl/abfr_pkg.sv */
// Package: types, constants and the density threshold table of the blob field renderer.
package abfr_pkg;

    localparam int BLOB_COUNT = 40;
    localparam int RADIUS     = 44;
    localparam int DIAM       = 2 * RADIUS;
    localparam int R2         = RADIUS * RADIUS;

    localparam int PIX_W   = 10;
    localparam int POS_W   = 11;
    localparam int COORD_W = POS_W + 1;
    localparam int IDX_W   = 6;
    localparam int STEP_W  = 3;
    localparam int DENS_W  = 8;
    localparam int COL_W   = $clog2(DIAM);
    localparam int DX_W    = COL_W + 1;
    localparam int D2_W    = $clog2(2 * R2 + 1);
    localparam int CNT_W   = (BLOB_COUNT > 1) ? $clog2(BLOB_COUNT) : 1;

    // density pipeline: one search step per result bit, plus d2 stages and accumulate
    localparam int DRAIN_LEN = DENS_W + 3;
    localparam int DRN_W     = $clog2(DRAIN_LEN);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic CMD_MOVE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [PIX_W-1:0] RST_WIDTH  = 10'd480;
    localparam logic [PIX_W-1:0] RST_HEIGHT = 10'd360;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic                    hidden;
    } t_blob;

    localparam t_blob BLOB_RESET = '{
        left:   POS_W'(int'(RST_WIDTH >> 1) - RADIUS),
        top:    POS_W'(int'(RST_HEIGHT >> 1) - RADIUS),
        hidden: 1'b0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef logic [(1<<DENS_W)-1:0][D2_W-1:0] t_thr_tab;

    // Largest d2 below R2 whose density is at least lvl:
    // 255 * (b - d2^2)^4 >= lvl * b^4 with b = R2^2.
    function automatic logic [D2_W-1:0] dens_thr(input int lvl);
        logic [127:0] bb;
        logic [127:0] aa;
        logic [127:0] lhs;
        logic [127:0] rhs;
        int           lo;
        int           hi;
        int           mid;
        bb  = 128'(R2) * 128'(R2);
        rhs = 128'(lvl) * bb * bb * bb * bb;
        lo  = 0;
        hi  = R2 - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            aa  = bb - 128'(mid) * 128'(mid);
            lhs = 128'(255) * aa * aa * aa * aa;
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return D2_W'(lo);
    endfunction

    function automatic t_thr_tab build_thr();
        t_thr_tab tab;
        for (int v = 0; v < (1 << DENS_W); v++) begin
            tab[v] = dens_thr(v);
        end
        return tab;
    endfunction

    // nonincreasing in the level; density(d2) = largest level with d2 <= THR_TAB[level]
    localparam t_thr_tab THR_TAB = build_thr();

endpackage

/* hdl/abfr_blob_cell.sv */
// One cell of the blob ring: holds one blob's position and hidden flag.
module abfr_blob_cell import abfr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_blob i_blob,
    output t_blob o_blob
);

    t_blob r_blob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob <= BLOB_RESET;
        end else if (i_shift) begin
            r_blob <= i_blob;
        end
    end

    assign o_blob = r_blob;

endmodule

/* hdl/abfr_dens_step.sv */
// One step of the pipelined density search: settles one bit of the density level.
module abfr_dens_step import abfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [D2_W-1:0]   i_d2,
    input  logic [DENS_W-1:0] i_level,
    input  logic [DENS_W-1:0] i_mask,
    output logic              o_valid,
    output logic [D2_W-1:0]   o_d2,
    output logic [DENS_W-1:0] o_level
);

    logic              r_valid;
    logic [D2_W-1:0]   r_d2;
    logic [DENS_W-1:0] r_level;
    logic [DENS_W-1:0] cand;
    logic              reach;

    assign cand  = i_level | i_mask;
    assign reach = (i_d2 <= THR_TAB[cand]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2    <= i_d2;
        r_level <= reach ? cand : i_level;
    end

    assign o_valid = r_valid;
    assign o_d2    = r_d2;
    assign o_level = r_level;

endmodule

/* hdl/additive_blob_field_renderer.sv */
// Top level of the additive blob field renderer: command port, blob ring, density pipeline.
//
// The blob states sit in a ring of BLOB_COUNT cells that rotates one place per
// clock during the scan, so every item takes one full turn of the ring: the
// scan state steps through all blobs, then the drain state lets the density
// search pipeline empty. The result strobe is registered from the last drain
// cycle; busy falls in the same cycle as the strobe, and a new item can start
// there, so the block takes no new item before the last one is through. Every
// item, move or query, gives exactly one result, shown for one cycle on
// o_strobe; the receiver cannot stall it. Configuration writes are
// always ready and are meant to be made while busy is low.
module additive_blob_field_renderer import abfr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cmd,
    input  logic [IDX_W-1:0]       i_blob_index,
    input  logic signed [STEP_W-1:0] i_step_x,
    input  logic signed [STEP_W-1:0] i_step_y,
    input  logic [PIX_W-1:0]       i_pixel_x,
    input  logic [PIX_W-1:0]       i_pixel_y,
    output logic                   o_strobe,
    output logic [DENS_W-1:0]      o_intensity,
    output logic                   o_blob_recentred,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [PIX_W-1:0]       i_cfg_data
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   scanning;

    logic [PIX_W-1:0] r_width;
    logic [PIX_W-1:0] r_height;

    logic                     r_cmd;
    logic [IDX_W-1:0]         r_idx;
    logic signed [STEP_W-1:0] r_sx;
    logic signed [STEP_W-1:0] r_sy;
    logic [PIX_W-1:0]         r_px;
    logic [PIX_W-1:0]         r_py;

    logic [CNT_W-1:0] r_cnt;
    logic [DRN_W-1:0] r_drain;

    logic [DENS_W-1:0] r_sum;
    logic              r_recent;

    logic              r_strobe;
    logic [DENS_W-1:0] r_out_int;
    logic              r_out_rec;

    // ring
    t_blob cell_out [BLOB_COUNT];
    t_blob head;
    t_blob tail_blob;
    t_blob moved;
    logic  hit;
    logic  in_win;

    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] lim_x;
    logic signed [COORD_W-1:0] lim_y;

    // query front stages
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      cov;
    logic                      r_p1_valid;
    logic                      r_p1_cov;
    logic [COL_W-1:0]          r_p1_col;
    logic [COL_W-1:0]          r_p1_row;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [2*DX_W-1:0]  sq_x;
    logic signed [2*DX_W-1:0]  sq_y;
    logic                      r_p2_valid;
    logic [D2_W-1:0]           r_p2_d2;

    // density search chain
    logic              stp_valid [DENS_W+1];
    logic [D2_W-1:0]   stp_d2    [DENS_W+1];
    logic [DENS_W-1:0] stp_level [DENS_W+1];
    logic [DENS_W:0]   sum_ext;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign scanning = (r_state == ST_SCAN);

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_W'(BLOB_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRN_W'(DRAIN_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_drain <= '0;
        end else begin
            if (accept) begin
                r_cnt <= '0;
            end else if (scanning) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_idx <= i_blob_index;
            r_sx  <= i_step_x;
            r_sy  <= i_step_y;
            r_px  <= i_pixel_x;
            r_py  <= i_pixel_y;
        end
    end

    // blob ring; cell 0 holds blob r_cnt during the scan
    assign head = cell_out[0];

    generate
        for (genvar c = 0; c < BLOB_COUNT; c++) begin : g_cell
            t_blob cell_in;
            if (c == BLOB_COUNT - 1) begin : g_tail
                assign cell_in = tail_blob;
            end else begin : g_mid
                assign cell_in = cell_out[c+1];
            end
            abfr_blob_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (scanning),
                .i_blob  (cell_in),
                .o_blob  (cell_out[c])
            );
        end
    endgenerate

    // move applied to the head as it wraps to the tail
    always_comb begin
        mx     = COORD_W'(head.left) + COORD_W'(r_sx);
        my     = COORD_W'(head.top) + COORD_W'(r_sy);
        lim_x  = $signed({2'b00, r_width}) - COORD_W'(DIAM);
        lim_y  = $signed({2'b00, r_height}) - COORD_W'(DIAM);
        in_win = (mx > 0) && (mx < lim_x) && (my > 0) && (my < lim_y);
        hit    = scanning && (r_cmd == CMD_MOVE) && (IDX_W'(r_cnt) == r_idx);
        if (in_win) begin
            moved.left   = mx[POS_W-1:0];
            moved.top    = my[POS_W-1:0];
            moved.hidden = 1'b0;
        end else begin
            moved.left   = $signed({2'b00, r_width[PIX_W-1:1]}) - POS_W'(RADIUS);
            moved.top    = $signed({2'b00, r_height[PIX_W-1:1]}) - POS_W'(RADIUS);
            moved.hidden = 1'b1;
        end
        tail_blob = hit ? moved : head;
    end

    // query stage 1: offset into the blob square and coverage
    always_comb begin
        col = $signed({2'b00, r_px}) - COORD_W'(head.left);
        row = $signed({2'b00, r_py}) - COORD_W'(head.top);
        cov = !head.hidden && (col >= 0) && (col < COORD_W'(DIAM))
              && (row >= 0) && (row < COORD_W'(DIAM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= scanning && (r_cmd == CMD_QUERY);
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_cov <= cov;
        r_p1_col <= col[COL_W-1:0];
        r_p1_row <= row[COL_W-1:0];
    end

    // query stage 2: squared distance from the center; uncovered reads as far away
    always_comb begin
        dx   = $signed({1'b0, r_p1_col}) - DX_W'(RADIUS);
        dy   = $signed({1'b0, r_p1_row}) - DX_W'(RADIUS);
        sq_x = dx * dx;
        sq_y = dy * dy;
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_cov) begin
            r_p2_d2 <= D2_W'($unsigned(sq_x)) + D2_W'($unsigned(sq_y));
        end else begin
            r_p2_d2 <= '1;
        end
    end

    // density search, MSB first
    assign stp_valid[0] = r_p2_valid;
    assign stp_d2[0]    = r_p2_d2;
    assign stp_level[0] = '0;

    generate
        for (genvar k = 0; k < DENS_W; k++) begin : g_step
            abfr_dens_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (stp_valid[k]),
                .i_d2    (stp_d2[k]),
                .i_level (stp_level[k]),
                .i_mask  (DENS_W'(1 << (DENS_W - 1 - k))),
                .o_valid (stp_valid[k+1]),
                .o_d2    (stp_d2[k+1]),
                .o_level (stp_level[k+1])
            );
        end
    endgenerate

    assign sum_ext = {1'b0, r_sum} + {1'b0, stp_level[DENS_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_recent <= 1'b0;
        end else if (accept) begin
            r_sum    <= '0;
            r_recent <= 1'b0;
        end else begin
            if (stp_valid[DENS_W]) begin
                r_sum <= sum_ext[DENS_W] ? '1 : sum_ext[DENS_W-1:0];
            end
            if (hit && !in_win) begin
                r_recent <= 1'b1;
            end
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_DRAIN) && (n_state == ST_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DRAIN) && (n_state == ST_IDLE)) begin
            r_out_int <= r_sum;
            r_out_rec <= r_recent;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_intensity      = r_out_int;
    assign o_blob_recentred = r_out_rec;

    `include "assert_macros.svh"

    // a result only ever follows the end of a drain
    `ABFR_ASSERT_IMP(a_strobe_after_drain, i_clk, i_rst_n, o_strobe, $past(r_state) == ST_DRAIN)
    // the density pipeline is empty whenever a new item may start
    `ABFR_ASSERT_IMP(a_pipe_empty_idle, i_clk, i_rst_n, r_state == ST_IDLE, !stp_valid[DENS_W] && !r_p1_valid && !r_p2_valid)
    // a fresh item starts its scan at blob 0 with a clear sum
    `ABFR_ASSERT_NXT(a_start_clean, i_clk, i_rst_n, accept, r_state == ST_SCAN && r_cnt == '0 && r_sum == '0)
    // a move never yields an intensity and a query never recenters
    `ABFR_ASSERT_IMP(a_result_kind, i_clk, i_rst_n, o_strobe, o_intensity == '0 || !o_blob_recentred)

endmodule

/* bench/testbench.sv */
// Testbench for the blob field renderer: directed table, then biased random items vs a predictor.
module testbench;
    import abfr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = BLOB_COUNT + DRAIN_LEN + 8;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int PIX_MAX      = (1 << PIX_W) - 1;

    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [DENS_W-1:0] intensity;
        logic              recentred;
    } t_result;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   cmd;
        logic [IDX_W-1:0]       idx;
        logic [STEP_W-1:0]      sx;
        logic [STEP_W-1:0]      sy;
        logic [PIX_W-1:0]       px;
        logic [PIX_W-1:0]       py;
        logic                   known;
        t_result                want;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [PIX_W-1:0]       cfg_data;
    } t_plan_row;

    typedef enum int { SCR_RANDOM, SCR_MIN, SCR_MAX, SCR_TINY, SCR_TIGHT, SCR_MIXED } t_scr_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cmd;
    logic [IDX_W-1:0]          i_blob_index;
    logic signed [STEP_W-1:0]  i_step_x;
    logic signed [STEP_W-1:0]  i_step_y;
    logic [PIX_W-1:0]          i_pixel_x;
    logic [PIX_W-1:0]          i_pixel_y;
    logic                      o_strobe;
    logic [DENS_W-1:0]         o_intensity;
    logic                      o_blob_recentred;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [PIX_W-1:0]          i_cfg_data;

    additive_blob_field_renderer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_blob_index     (i_blob_index),
        .i_step_x         (i_step_x),
        .i_step_y         (i_step_y),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .o_strobe         (o_strobe),
        .o_intensity      (o_intensity),
        .o_blob_recentred (o_blob_recentred),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor state
    logic [DENS_W-1:0] falloff [R2];
    int                mdl_left   [BLOB_COUNT];
    int                mdl_top    [BLOB_COUNT];
    bit                mdl_hidden [BLOB_COUNT];
    int                mdl_width;
    int                mdl_height;

    t_result   pending_results [$];
    t_plan_row plan [$];
    t_result   head_result;

    int err_count;
    int result_count;
    int quiet_cycles;
    int n_moves, n_recentred, n_ignored, n_queries, n_saturated, n_partial, n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void fill_falloff();
        logic [127:0] bb;
        logic [127:0] aa;
        logic [127:0] den;
        bb  = 128'(R2) * 128'(R2);
        den = bb * bb * bb * bb;
        for (int d2 = 0; d2 < R2; d2++) begin
            aa = bb - 128'(d2) * 128'(d2);
            falloff[d2] = DENS_W'((128'd255 * aa * aa * aa * aa) / den);
        end
    endfunction

    function automatic void recenter_blob(int i);
        mdl_left[i] = (mdl_width >> 1) - RADIUS;
        mdl_top[i]  = (mdl_height >> 1) - RADIUS;
    endfunction

    // one item through the predicted blob field; updates positions on a move
    function automatic t_result field_model_step(logic cmd, logic [IDX_W-1:0] idx,
                                                 logic signed [STEP_W-1:0] sx,
                                                 logic signed [STEP_W-1:0] sy,
                                                 logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        t_result r;
        int      nx;
        int      ny;
        int      col;
        int      row;
        int      d2;
        int      acc;
        r = '0;
        if (cmd == CMD_MOVE) begin
            if (idx < BLOB_COUNT) begin
                nx = mdl_left[idx] + int'(sx);
                ny = mdl_top[idx] + int'(sy);
                if (nx > 0 && nx < mdl_width - DIAM && ny > 0 && ny < mdl_height - DIAM) begin
                    mdl_left[idx]   = nx;
                    mdl_top[idx]    = ny;
                    mdl_hidden[idx] = 1'b0;
                end else begin
                    recenter_blob(int'(idx));
                    mdl_hidden[idx] = 1'b1;
                    r.recentred     = 1'b1;
                end
            end
        end else begin
            acc = 0;
            for (int i = 0; i < BLOB_COUNT; i++) begin
                col = int'(px) - mdl_left[i];
                row = int'(py) - mdl_top[i];
                if (!mdl_hidden[i] && col >= 0 && col < DIAM && row >= 0 && row < DIAM) begin
                    d2 = (col - RADIUS) * (col - RADIUS) + (row - RADIUS) * (row - RADIUS);
                    if (d2 < R2) acc += int'(falloff[d2]);
                    if (acc > 255) acc = 255;
                end
            end
            r.intensity = DENS_W'(acc);
        end
        return r;
    endfunction

    function automatic t_plan_row item_row(logic cmd, int idx, int sx, int sy, int px, int py,
                                           bit known, int w_int, bit w_rec);
        t_plan_row p;
        p            = '0;
        p.kind       = ROW_ITEM;
        p.cmd        = cmd;
        p.idx        = IDX_W'(idx);
        p.sx         = STEP_W'(sx);
        p.sy         = STEP_W'(sy);
        p.px         = PIX_W'(px);
        p.py         = PIX_W'(py);
        p.known      = known;
        p.want.intensity = DENS_W'(w_int);
        p.want.recentred = w_rec;
        return p;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] ix, int data);
        t_plan_row p;
        p          = '0;
        p.kind     = ROW_CFG;
        p.cfg_idx  = ix;
        p.cfg_data = PIX_W'(data);
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 45) return 0;
        if (r < 85) return int'($urandom_range(1, 8));
        if (r < 97) return int'($urandom_range(9, 60));
        return int'($urandom_range(61, 150));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d want %0d", result_count, what, got, want);
        err_count++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until the block has answered everything and is idle
    task automatic drain_results();
        if (pending_results.size() != 0 || busy) begin
            start <= 1'b0;
            while (pending_results.size() != 0 || busy) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] ix, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data  <= PIX_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (ix == CFG_WIDTH) mdl_width = data & PIX_MAX;
        else if (ix == CFG_HEIGHT) mdl_height = data & PIX_MAX;
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, logic [STEP_W-1:0] sx,
                             logic [STEP_W-1:0] sy, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                             bit known, t_result want);
        t_result r;
        i_cfg_valid  <= 1'b0;
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_blob_index <= idx;
        i_step_x     <= sx;
        i_step_y     <= sy;
        i_pixel_x    <= px;
        i_pixel_y    <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = field_model_step(cmd, idx, sx, sy, px, py);
        if (known) r = want;
        pending_results.push_back(r);
        if (cmd == CMD_MOVE) begin
            n_moves++;
            if (idx >= BLOB_COUNT) n_ignored++;
            if (r.recentred) n_recentred++;
        end else begin
            n_queries++;
            if (r.intensity == 8'hFF) n_saturated++;
            else if (r.intensity != 8'h00) n_partial++;
        end
    endtask

    // result checker and quiet-cycle counter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, intensity", o_intensity, 0);
                end else begin
                    head_result = pending_results.pop_front();
                    if (o_intensity !== head_result.intensity)
                        report_mismatch("intensity", o_intensity, head_result.intensity);
                    if (o_blob_recentred !== head_result.recentred)
                        report_mismatch("blob_recentred", o_blob_recentred,
                                        head_result.recentred);
                end
                result_count++;
            end
            if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        t_scr_mode mode;
        int        w;
        int        h;
        int        focus;
        int        drift_x;
        int        drift_y;
        int        r;
        int        sxi;
        int        syi;
        int        idx;
        int        bi;
        int        pxi;
        int        pyi;
        logic      cmd;
        bit        no_gaps;
        t_result   none;

        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_cmd        = CMD_MOVE;
        i_blob_index = '0;
        i_step_x     = '0;
        i_step_y     = '0;
        i_pixel_x    = '0;
        i_pixel_y    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_WIDTH;
        i_cfg_data   = '0;
        err_count    = 0;
        result_count = 0;
        quiet_cycles = 0;
        none         = '0;
        {n_moves, n_recentred, n_ignored, n_queries, n_saturated, n_partial, n_cfg} = '0;

        fill_falloff();
        mdl_width  = int'(RST_WIDTH);
        mdl_height = int'(RST_HEIGHT);
        for (int i = 0; i < BLOB_COUNT; i++) begin
            recenter_blob(i);
            mdl_hidden[i] = 1'b0;
        end

        // all blobs start stacked on the screen center
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 240, 180, 1, 255, 0));
        plan.push_back(item_row(CMD_QUERY, 63, 0, 0, 0, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, PIX_MAX, PIX_MAX, 1, 0, 0));
        plan.push_back(item_row(CMD_MOVE, 63, 1, 1, 0, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_MOVE, BLOB_COUNT, -1, -1, 0, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_MOVE, 0, 3, 3, PIX_MAX, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_MOVE, 1, -4, -4, 0, PIX_MAX, 1, 0, 0));
        plan.push_back(item_row(CMD_MOVE, 2, 2, -2, 0, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 243, 183, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 196, 136, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 283, 223, 0, 0, 0));
        // shrink the width below the current positions: visible blobs stay put
        plan.push_back(cfg_row(CFG_WIDTH, 96));
        plan.push_back(item_row(CMD_MOVE, 3, 1, 1, 0, 0, 1, 0, 1));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 240, 180, 0, 0, 0));
        plan.push_back(cfg_row(CFG_HEIGHT, 96));
        plan.push_back(item_row(CMD_MOVE, 3, 2, 2, 0, 0, 1, 0, 1));
        plan.push_back(item_row(CMD_MOVE, 3, 2, 2, 0, 0, 1, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 50, 50, 0, 0, 0));
        // width too small for any legal position
        plan.push_back(cfg_row(CFG_WIDTH, 50));
        plan.push_back(item_row(CMD_MOVE, 4, 0, 0, 0, 0, 1, 0, 1));
        plan.push_back(cfg_row(CFG_SPARE_A, PIX_MAX));
        plan.push_back(cfg_row(CFG_SPARE_B, 0));
        plan.push_back(item_row(CMD_MOVE, 4, 1, 1, 0, 0, 0, 0, 0));
        plan.push_back(cfg_row(CFG_WIDTH, PIX_MAX));
        plan.push_back(cfg_row(CFG_HEIGHT, PIX_MAX));
        plan.push_back(item_row(CMD_MOVE, 4, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(item_row(CMD_MOVE, 4, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, PIX_MAX, 0, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 0, PIX_MAX, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0, 511, 511, 0, 0, 0));
        plan.push_back(item_row(CMD_MOVE, BLOB_COUNT - 1, -2, 2, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                drain_results();
                cfg_write(plan[k].cfg_idx, int'(plan[k].cfg_data));
            end else begin
                idle_gap(pick_gap());
                send_item(plan[k].cmd, plan[k].idx, plan[k].sx, plan[k].sy,
                          plan[k].px, plan[k].py, plan[k].known, plan[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            mode = (ph < 6) ? t_scr_mode'(ph) : t_scr_mode'($urandom_range(0, 5));
            case (mode)
                SCR_MIN:    begin w = 96;      h = 96;      end
                SCR_MAX:    begin w = PIX_MAX; h = PIX_MAX; end
                SCR_TINY:   begin
                    w = int'($urandom_range(0, 95));
                    h = int'($urandom_range(96, PIX_MAX));
                    if ($urandom_range(0, 1)) begin r = w; w = h; h = r; end
                end
                SCR_TIGHT:  begin
                    w = int'($urandom_range(96, 260));
                    h = int'($urandom_range(96, 260));
                end
                SCR_MIXED:  begin w = PIX_MAX; h = 96; end
                default:    begin
                    w = int'($urandom_range(96, PIX_MAX));
                    h = int'($urandom_range(96, PIX_MAX));
                end
            endcase
            cfg_write(CFG_WIDTH, w);
            cfg_write(CFG_HEIGHT, h);
            if ($urandom_range(0, 3) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          int'($urandom_range(0, PIX_MAX)));

            // a few blobs get most of the moves and share a drift, so they reach the edges
            focus   = int'($urandom_range(0, BLOB_COUNT - 6));
            drift_x = int'($urandom_range(0, 4)) - 2;
            drift_y = int'($urandom_range(0, 4)) - 2;
            no_gaps = ($urandom_range(0, 2) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_MOVE;
                r = int'($urandom_range(0, 99));
                if (r < 70) idx = focus + int'($urandom_range(0, 5));
                else if (r < 90) idx = int'($urandom_range(0, BLOB_COUNT - 1));
                else idx = int'($urandom_range(BLOB_COUNT, (1 << IDX_W) - 1));

                r = int'($urandom_range(0, 99));
                if (r < 65) begin
                    sxi = drift_x;
                    syi = drift_y;
                end else if (r < 92) begin
                    sxi = int'($urandom_range(0, 4)) - 2;
                    syi = int'($urandom_range(0, 4)) - 2;
                end else begin
                    sxi = int'($urandom_range(0, 7)) - 4;
                    syi = int'($urandom_range(0, 7)) - 4;
                end

                pxi = int'($urandom_range(0, PIX_MAX));
                pyi = int'($urandom_range(0, PIX_MAX));
                if (cmd == CMD_QUERY && $urandom_range(0, 99) < 70) begin
                    // aim at or just around one blob's square
                    bi  = ($urandom_range(0, 1)) ? focus + int'($urandom_range(0, 5))
                                                 : int'($urandom_range(0, BLOB_COUNT - 1));
                    pxi = mdl_left[bi] + int'($urandom_range(0, DIAM + 7)) - 4;
                    pyi = mdl_top[bi] + int'($urandom_range(0, DIAM + 7)) - 4;
                    if (pxi < 0 || pxi > PIX_MAX) pxi = int'($urandom_range(0, PIX_MAX));
                    if (pyi < 0 || pyi > PIX_MAX) pyi = int'($urandom_range(0, PIX_MAX));
                end

                if ($urandom_range(0, 59) == 0) drain_results();
                if (!no_gaps) idle_gap(pick_gap());
                send_item(cmd, IDX_W'(idx), STEP_W'(sxi), STEP_W'(syi),
                          PIX_W'(pxi), PIX_W'(pyi), 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d moves (%0d recentred, %0d out-of-range index), %0d queries",
                 n_moves, n_recentred, n_ignored, n_queries);
        $display("queries: %0d saturated, %0d partial sums; %0d register writes; %0d results",
                 n_saturated, n_partial, n_cfg, result_count);
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d mismatches", err_count);
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
